// ===== src/gel_pkg.sv =====
// Shared types and constants for the gear event logger.
// No dependencies; imported by every module of the block.
`default_nettype none

package gel_pkg;

  localparam int unsigned LOG_DEPTH = 10;
  localparam int unsigned PTR_W     = $clog2(LOG_DEPTH);
  localparam int unsigned CNT_W     = $clog2(LOG_DEPTH + 1);
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned CMP_W     = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int unsigned SUM_W     = ((PTR_W > IDX_W) ? PTR_W : IDX_W) + 1;

  localparam int unsigned ADC_W   = 10;
  localparam int unsigned SPEED_W = 7;
  localparam int unsigned EVENT_W = 4;
  localparam int unsigned KEY_W   = 3;

  // Speed is adc * 100 / 1033; 100 * ceil(2^28 / 1033) folded into one constant.
  localparam int unsigned SPEED_SHIFT = 28;
  localparam int unsigned SPEED_MUL_W = 25;
  localparam logic [SPEED_MUL_W-1:0] SPEED_MUL = 25'd25986100;
  localparam int unsigned PROD_W = ADC_W + SPEED_MUL_W;

  localparam logic [KEY_W-1:0] KEY_SW1 = 3'd1;
  localparam logic [KEY_W-1:0] KEY_SW2 = 3'd2;
  localparam logic [KEY_W-1:0] KEY_SW3 = 3'd3;
  localparam logic [KEY_W-1:0] KEY_SW4 = 3'd4;

  localparam logic [EVENT_W-1:0] EV_ON        = 4'd0;
  localparam logic [EVENT_W-1:0] EV_LOW_LIMIT = 4'd1;
  localparam logic [EVENT_W-1:0] EV_GN        = 4'd2;
  localparam logic [EVENT_W-1:0] EV_TOP_GEAR  = 4'd7;
  localparam logic [EVENT_W-1:0] EV_COLLISION = 4'd8;

  localparam logic REQ_KEY  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef struct packed {
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;
    logic [EVENT_W-1:0] event_idx;
    logic [SPEED_W-1:0] speed;
  } rec_t;

  typedef struct packed {
    logic             we;
    logic [PTR_W-1:0] waddr;
    rec_t             wdata;
    logic             re;
    logic [PTR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [EVENT_W-1:0] event_idx;
    logic               go_menu;
    logic               logged;
    logic               rec_valid;
  } dec_t;

endpackage

`default_nettype wire

// ===== src/gel_speed.sv =====
// Speed scaling: adc * 100 / 1033 by a constant reciprocal multiply.
// Depends on gel_pkg.
`default_nettype none

module gel_speed (
  input  wire logic [gel_pkg::ADC_W-1:0]   adc_i,
  output logic      [gel_pkg::SPEED_W-1:0] speed_o
);
  import gel_pkg::*;

  logic [PROD_W-1:0] prod;

  assign prod    = PROD_W'(adc_i) * PROD_W'(SPEED_MUL);
  assign speed_o = prod[SPEED_SHIFT +: SPEED_W];

endmodule

`default_nettype wire

// ===== src/gel_log_ram.sv =====
// Record store: one write port and one registered read port.
// Depends on gel_pkg.
`default_nettype none

module gel_log_ram (
  input  wire logic              clk_i,
  input  wire gel_pkg::mem_req_t req_i,
  output gel_pkg::rec_t          rdata_o
);
  import gel_pkg::*;

  rec_t mem_q [LOG_DEPTH];
  rec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/gel_ctrl.sv =====
// Event index state, ring pointers and log memory address generation.
// Depends on gel_pkg.
`default_nettype none

module gel_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          accept_i,
  input  wire logic                          req_type_i,
  input  wire logic [gel_pkg::KEY_W-1:0]     key_i,
  input  wire logic [4:0]                    hour_i,
  input  wire logic [5:0]                    minute_i,
  input  wire logic [5:0]                    second_i,
  input  wire logic [gel_pkg::SPEED_W-1:0]   speed_i,
  input  wire logic [gel_pkg::IDX_W-1:0]     read_index_i,
  output gel_pkg::dec_t                      dec_o,
  output gel_pkg::mem_req_t                  mem_req_o
);
  import gel_pkg::*;

  logic [EVENT_W-1:0] event_q, event_d;
  logic [PTR_W-1:0]   head_q, head_d;
  logic [CNT_W-1:0]   count_q, count_d;

  logic               do_log;
  logic               menu;
  logic               full;
  logic               in_range;
  logic [PTR_W-1:0]   oldest;
  logic [SUM_W-1:0]   rd_sum;
  logic [SUM_W-1:0]   rd_wrap;

  always_comb begin
    event_d = event_q;
    do_log  = 1'b0;
    menu    = 1'b0;
    if (req_type_i == REQ_KEY) begin
      if (event_q == EV_COLLISION) begin
        if (key_i == KEY_SW1 || key_i == KEY_SW2) begin
          event_d = EV_GN;
          do_log  = 1'b1;
        end
      end else begin
        case (key_i)
          KEY_SW1: begin
            if (event_q < EV_TOP_GEAR) event_d = event_q + 1'b1;
            do_log = 1'b1;
          end
          KEY_SW2: begin
            if (event_q > EV_LOW_LIMIT) event_d = event_q - 1'b1;
            do_log = 1'b1;
          end
          KEY_SW3: begin
            event_d = EV_COLLISION;
            do_log  = 1'b1;
          end
          KEY_SW4: begin
            menu = 1'b1;
          end
          default: begin
            menu = 1'b0;
          end
        endcase
      end
    end
  end

  assign full     = (count_q == CNT_W'(LOG_DEPTH));
  assign in_range = (req_type_i == REQ_READ) && (CMP_W'(read_index_i) < CMP_W'(count_q));
  assign oldest   = full ? head_q : '0;
  assign rd_sum   = SUM_W'(oldest) + SUM_W'(read_index_i);
  assign rd_wrap  = (rd_sum >= SUM_W'(LOG_DEPTH)) ? (rd_sum - SUM_W'(LOG_DEPTH)) : rd_sum;

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (accept_i && do_log) begin
      head_d = (head_q == PTR_W'(LOG_DEPTH - 1)) ? '0 : head_q + 1'b1;
      if (!full) count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      event_q <= EV_ON;
      head_q  <= '0;
      count_q <= '0;
    end else if (accept_i) begin
      event_q <= event_d;
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  assign dec_o.event_idx = event_d;
  assign dec_o.go_menu   = menu;
  assign dec_o.logged    = do_log;
  assign dec_o.rec_valid = in_range;

  assign mem_req_o.we              = accept_i && do_log;
  assign mem_req_o.waddr           = head_q;
  assign mem_req_o.wdata.hour      = hour_i;
  assign mem_req_o.wdata.minute    = minute_i;
  assign mem_req_o.wdata.second    = second_i;
  assign mem_req_o.wdata.event_idx = event_d;
  assign mem_req_o.wdata.speed     = speed_i;
  assign mem_req_o.re              = accept_i && in_range;
  assign mem_req_o.raddr           = rd_wrap[PTR_W-1:0];

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(LOG_DEPTH))
    else $error("Log count exceeds the log depth.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q < CNT_W'(LOG_DEPTH)) |-> (CNT_W'(head_q) == count_q))
    else $error("Write pointer and count disagree before the log fills.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    event_q <= EV_COLLISION)
    else $error("Event index out of range.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_req_o.we && mem_req_o.re))
    else $error("Log memory read and write in the same transaction.");

endmodule

`default_nettype wire

// ===== src/gear_event_logger_core.sv =====
// Gear event logger: one transaction in, one result out.
// A new transaction is accepted every cycle while the output register is empty or
// being taken; the result is valid in the cycle after acceptance, its record taken
// from the registered read port of the record memory. Records are stored in a ring of
// gel_pkg::LOG_DEPTH entries that overwrites the oldest one when full.
// Depends on gel_pkg, gel_speed, gel_ctrl and gel_log_ram.
`default_nettype none

module gear_event_logger_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          req_type_i,
  input  wire logic [gel_pkg::KEY_W-1:0]     key_i,
  input  wire logic [4:0]                    hour_i,
  input  wire logic [5:0]                    minute_i,
  input  wire logic [5:0]                    second_i,
  input  wire logic [gel_pkg::ADC_W-1:0]     adc_value_i,
  input  wire logic [gel_pkg::IDX_W-1:0]     read_index_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [gel_pkg::EVENT_W-1:0]   event_index_o,
  output logic      [gel_pkg::SPEED_W-1:0]   speed_o,
  output logic                               go_menu_o,
  output logic                               logged_o,
  output logic                               rec_valid_o,
  output logic      [4:0]                    rec_hour_o,
  output logic      [5:0]                    rec_minute_o,
  output logic      [5:0]                    rec_second_o,
  output logic      [gel_pkg::EVENT_W-1:0]   rec_event_o,
  output logic      [gel_pkg::SPEED_W-1:0]   rec_speed_o
);
  import gel_pkg::*;

  logic               accept;
  logic [SPEED_W-1:0] speed;
  dec_t               dec;
  mem_req_t           mem_req;
  rec_t               rdata;

  logic               out_valid_q, out_valid_d;
  dec_t               dec_q;
  logic [SPEED_W-1:0] speed_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  gel_speed u_speed (
    .adc_i   (adc_value_i),
    .speed_o (speed)
  );

  gel_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .req_type_i   (req_type_i),
    .key_i        (key_i),
    .hour_i       (hour_i),
    .minute_i     (minute_i),
    .second_i     (second_i),
    .speed_i      (speed),
    .read_index_i (read_index_i),
    .dec_o        (dec),
    .mem_req_o    (mem_req)
  );

  gel_log_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dec_q   <= dec;
      speed_q <= speed;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_index_o = dec_q.event_idx;
  assign speed_o       = speed_q;
  assign go_menu_o     = dec_q.go_menu;
  assign logged_o      = dec_q.logged;
  assign rec_valid_o   = dec_q.rec_valid;
  assign rec_hour_o    = dec_q.rec_valid ? rdata.hour      : '0;
  assign rec_minute_o  = dec_q.rec_valid ? rdata.minute    : '0;
  assign rec_second_o  = dec_q.rec_valid ? rdata.second    : '0;
  assign rec_event_o   = dec_q.rec_valid ? rdata.event_idx : '0;
  assign rec_speed_o   = dec_q.rec_valid ? rdata.speed     : '0;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("Transaction accepted while a result is stalled.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("Accepted transaction produced no result.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(dec_q.logged && dec_q.rec_valid))
    else $error("Result marks both a logged key and a record read.");

endmodule

`default_nettype wire

// ===== tb/sv/gear_event_logger_core_tb.sv =====
// Self-checking testbench for gear_event_logger_core: a directed table followed by
// random key and log-read transactions, checked against an in-bench model of the logger.
// Depends on gel_pkg and gear_event_logger_core.
`timescale 1ns / 1ps

module gear_event_logger_core_tb;
  import gel_pkg::*;

  localparam int unsigned RAND_ITEMS   = 1400;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned MAX_REPORTS  = 40;

  localparam logic [KEY_W-1:0] KEY_NONE = 3'd0;
  localparam logic [KEY_W-1:0] KEY_RSV5 = 3'd5;
  localparam logic [KEY_W-1:0] KEY_RSV6 = 3'd6;
  localparam logic [KEY_W-1:0] KEY_RSV7 = 3'd7;

  typedef struct packed {
    logic               req;
    logic [KEY_W-1:0]   key;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;
    logic [ADC_W-1:0]   adc;
    logic [IDX_W-1:0]   idx;
  } item_t;

  typedef struct packed {
    logic [EVENT_W-1:0] event_index;
    logic [SPEED_W-1:0] speed;
    logic               go_menu;
    logic               logged;
    logic               rec_valid;
    rec_t               rec;
  } result_t;

  typedef struct packed {
    item_t   it;
    logic    typed;
    result_t res;
  } dir_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 req_type_i;
  logic [KEY_W-1:0]     key_i;
  logic [4:0]           hour_i;
  logic [5:0]           minute_i;
  logic [5:0]           second_i;
  logic [ADC_W-1:0]     adc_value_i;
  logic [IDX_W-1:0]     read_index_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [EVENT_W-1:0]   event_index_o;
  logic [SPEED_W-1:0]   speed_o;
  logic                 go_menu_o;
  logic                 logged_o;
  logic                 rec_valid_o;
  logic [4:0]           rec_hour_o;
  logic [5:0]           rec_minute_o;
  logic [5:0]           rec_second_o;
  logic [EVENT_W-1:0]   rec_event_o;
  logic [SPEED_W-1:0]   rec_speed_o;

  gear_event_logger_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .key_i        (key_i),
    .hour_i       (hour_i),
    .minute_i     (minute_i),
    .second_i     (second_i),
    .adc_value_i  (adc_value_i),
    .read_index_i (read_index_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .event_index_o(event_index_o),
    .speed_o      (speed_o),
    .go_menu_o    (go_menu_o),
    .logged_o     (logged_o),
    .rec_valid_o  (rec_valid_o),
    .rec_hour_o   (rec_hour_o),
    .rec_minute_o (rec_minute_o),
    .rec_second_o (rec_second_o),
    .rec_event_o  (rec_event_o),
    .rec_speed_o  (rec_speed_o)
  );

  always #6 clk_i = ~clk_i;

  // Logger model state.
  logic [EVENT_W-1:0] gear_event;
  rec_t               rec_ring [LOG_DEPTH];
  int unsigned        rec_count;
  int unsigned        rec_wr_ptr;

  result_t     pending_results [$];
  dir_row_t    dir_rows [$];
  logic        cur_typed;
  result_t     cur_typed_res;
  logic        no_idle;
  int unsigned accepted_items;
  int unsigned checked_results;
  int unsigned logged_records;
  int unsigned stored_reads;
  int unsigned mismatches;

  function automatic logic [SPEED_W-1:0] speed_from_adc(logic [ADC_W-1:0] adc);
    int unsigned scaled;
    scaled = (int'(adc) * 100) / 1033;
    return scaled[SPEED_W-1:0];
  endfunction

  function automatic result_t step_logger(item_t it);
    result_t     r;
    logic        wr;
    int unsigned slot;
    r  = '0;
    wr = 1'b0;
    if (it.req == REQ_KEY) begin
      if (gear_event == EV_COLLISION) begin
        if (it.key == KEY_SW1 || it.key == KEY_SW2) begin
          gear_event = EV_GN;
          wr = 1'b1;
        end
      end else begin
        case (it.key)
          KEY_SW1: begin
            if (gear_event < EV_TOP_GEAR) gear_event = gear_event + 1'b1;
            wr = 1'b1;
          end
          KEY_SW2: begin
            if (gear_event > EV_LOW_LIMIT) gear_event = gear_event - 1'b1;
            wr = 1'b1;
          end
          KEY_SW3: begin
            gear_event = EV_COLLISION;
            wr = 1'b1;
          end
          KEY_SW4: begin
            r.go_menu = 1'b1;
          end
          default: begin
          end
        endcase
      end
      if (wr) begin
        rec_ring[rec_wr_ptr].hour      = it.hour;
        rec_ring[rec_wr_ptr].minute    = it.minute;
        rec_ring[rec_wr_ptr].second    = it.second;
        rec_ring[rec_wr_ptr].event_idx = gear_event;
        rec_ring[rec_wr_ptr].speed     = speed_from_adc(it.adc);
        rec_wr_ptr = (rec_wr_ptr + 1) % LOG_DEPTH;
        if (rec_count < LOG_DEPTH) rec_count++;
        r.logged = 1'b1;
      end
    end else if (it.idx < rec_count) begin
      slot = (((rec_count < LOG_DEPTH) ? 0 : rec_wr_ptr) + it.idx) % LOG_DEPTH;
      r.rec_valid = 1'b1;
      r.rec       = rec_ring[slot];
    end
    r.event_index = gear_event;
    r.speed       = speed_from_adc(it.adc);
    return r;
  endfunction

  function automatic item_t mk_item(logic req, logic [KEY_W-1:0] key, logic [4:0] hour,
                                    logic [5:0] minute, logic [5:0] second,
                                    logic [ADC_W-1:0] adc, logic [IDX_W-1:0] idx);
    item_t it;
    it.req    = req;
    it.key    = key;
    it.hour   = hour;
    it.minute = minute;
    it.second = second;
    it.adc    = adc;
    it.idx    = idx;
    return it;
  endfunction

  function automatic result_t mk_res(logic [EVENT_W-1:0] ev, logic [SPEED_W-1:0] sp,
                                     logic menu, logic logged);
    result_t r;
    r             = '0;
    r.event_index = ev;
    r.speed       = sp;
    r.go_menu     = menu;
    r.logged      = logged;
    return r;
  endfunction

  task automatic add_row(item_t it, logic typed, result_t res);
    dir_row_t row;
    row.it    = it;
    row.typed = typed;
    row.res   = res;
    dir_rows.push_back(row);
  endtask

  function automatic item_t rand_item();
    item_t       it;
    int unsigned p;
    it.req    = ($urandom_range(99) < 55) ? REQ_KEY : REQ_READ;
    it.hour   = 5'($urandom_range(23));
    it.minute = 6'($urandom_range(59));
    it.second = 6'($urandom_range(59));
    p = $urandom_range(99);
    if (p < 10) it.adc = '0;
    else if (p < 20) it.adc = '1;
    else it.adc = ADC_W'($urandom_range(1023));
    p = $urandom_range(99);
    if (p < 35) it.key = KEY_SW1;
    else if (p < 65) it.key = KEY_SW2;
    else if (p < 80) it.key = KEY_SW3;
    else if (p < 92) it.key = KEY_SW4;
    else it.key = KEY_W'($urandom_range(7));
    if ($urandom_range(99) < 85) it.idx = IDX_W'($urandom_range(LOG_DEPTH - 1));
    else it.idx = IDX_W'($urandom_range(15));
    return it;
  endfunction

  task automatic drive_item(item_t it, logic typed, result_t res);
    int unsigned seen;
    while (!no_idle && $urandom_range(99) < 11) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    req_type_i    = it.req;
    key_i         = it.key;
    hour_i        = it.hour;
    minute_i      = it.minute;
    second_i      = it.second;
    adc_value_i   = it.adc;
    read_index_i  = it.idx;
    cur_typed     = typed;
    cur_typed_res = res;
    in_valid_i    = 1'b1;
    seen = accepted_items;
    do @(negedge clk_i); while (accepted_items == seen);
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(negedge clk_i) begin
    out_ready_i = no_idle || ($urandom_range(99) >= 11);
  end

  always @(posedge clk_i) begin : monitor
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got.event_index   = event_index_o;
        got.speed         = speed_o;
        got.go_menu       = go_menu_o;
        got.logged        = logged_o;
        got.rec_valid     = rec_valid_o;
        got.rec.hour      = rec_hour_o;
        got.rec.minute    = rec_minute_o;
        got.rec.second    = rec_second_o;
        got.rec.event_idx = rec_event_o;
        got.rec.speed     = rec_speed_o;
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: result transaction with no expectation waiting, expected none, actual %h",
                   $time, got);
        end else begin
          want = pending_results.pop_front();
          checked_results++;
          check_field("event_index", want.event_index, got.event_index);
          check_field("speed", want.speed, got.speed);
          check_field("go_menu", want.go_menu, got.go_menu);
          check_field("logged", want.logged, got.logged);
          check_field("rec_valid", want.rec_valid, got.rec_valid);
          check_field("rec_hour", want.rec.hour, got.rec.hour);
          check_field("rec_minute", want.rec.minute, got.rec.minute);
          check_field("rec_second", want.rec.second, got.rec.second);
          check_field("rec_event", want.rec.event_idx, got.rec.event_idx);
          check_field("rec_speed", want.rec.speed, got.rec.speed);
        end
      end
      if (in_valid_i && in_ready_o) begin
        want = step_logger(mk_item(req_type_i, key_i, hour_i, minute_i, second_i,
                                   adc_value_i, read_index_i));
        if (want.logged) logged_records++;
        if (want.rec_valid) stored_reads++;
        pending_results.push_back(cur_typed ? cur_typed_res : want);
        accepted_items++;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    wait (rst_ni === 1'b1);
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    item_t       it;
    int unsigned counted;
    int unsigned drawn;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    req_type_i      = REQ_KEY;
    key_i           = KEY_NONE;
    hour_i          = '0;
    minute_i        = '0;
    second_i        = '0;
    adc_value_i     = '0;
    read_index_i    = '0;
    out_ready_i     = 1'b0;
    no_idle         = 1'b0;
    cur_typed       = 1'b0;
    cur_typed_res   = '0;
    gear_event      = EV_ON;
    rec_count       = 0;
    rec_wr_ptr      = 0;
    accepted_items  = 0;
    checked_results = 0;
    logged_records  = 0;
    stored_reads    = 0;
    mismatches      = 0;
    foreach (rec_ring[i]) rec_ring[i] = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    add_row(mk_item(REQ_READ, KEY_NONE, 0, 0, 0, 0, 0), 1'b1, mk_res(EV_ON, 0, 0, 0));
    add_row(mk_item(REQ_KEY, KEY_SW2, 0, 0, 0, 0, 0), 1'b1, mk_res(EV_ON, 0, 0, 1));
    add_row(mk_item(REQ_KEY, KEY_SW4, 1, 2, 3, 1023, 0), 1'b1, mk_res(EV_ON, 99, 1, 0));
    add_row(mk_item(REQ_KEY, KEY_NONE, 4, 5, 6, 1023, 0), 1'b1, mk_res(EV_ON, 99, 0, 0));
    add_row(mk_item(REQ_KEY, KEY_RSV5, 7, 8, 9, 300, 15), 1'b0, '0);
    add_row(mk_item(REQ_KEY, KEY_RSV6, 10, 11, 12, 600, 0), 1'b0, '0);
    add_row(mk_item(REQ_KEY, KEY_RSV7, 13, 14, 15, 900, 5), 1'b0, '0);
    add_row(mk_item(REQ_READ, KEY_SW1, 0, 0, 0, 512, 0), 1'b0, '0);
    add_row(mk_item(REQ_READ, KEY_SW3, 0, 0, 0, 1, 1), 1'b0, '0);
    add_row(mk_item(REQ_KEY, KEY_SW1, 23, 59, 59, 1023, 0), 1'b0, '0);
    add_row(mk_item(REQ_KEY, KEY_SW1, 16, 32, 32, 1, 0), 1'b0, '0);
    add_row(mk_item(REQ_KEY, KEY_SW1, 8, 16, 16, 10, 0), 1'b0, '0);
    add_row(mk_item(REQ_KEY, KEY_SW1, 4, 8, 8, 100, 0), 1'b0, '0);
    add_row(mk_item(REQ_KEY, KEY_SW1, 2, 4, 4, 1022, 0), 1'b0, '0);
    add_row(mk_item(REQ_KEY, KEY_SW1, 1, 2, 2, 1033 / 100, 0), 1'b0, '0);
    add_row(mk_item(REQ_KEY, KEY_SW1, 12, 30, 45, 777, 0), 1'b0, '0);
    add_row(mk_item(REQ_KEY, KEY_SW1, 0, 0, 0, 255, 0), 1'b0, '0);
    add_row(mk_item(REQ_KEY, KEY_SW3, 5, 5, 5, 0, 0), 1'b1, mk_res(EV_COLLISION, 0, 0, 1));
    add_row(mk_item(REQ_KEY, KEY_SW3, 6, 6, 6, 0, 0), 1'b1, mk_res(EV_COLLISION, 0, 0, 0));
    add_row(mk_item(REQ_KEY, KEY_SW4, 7, 7, 7, 0, 0), 1'b1, mk_res(EV_COLLISION, 0, 0, 0));
    add_row(mk_item(REQ_KEY, KEY_SW1, 8, 8, 8, 1023, 0), 1'b1, mk_res(EV_GN, 99, 0, 1));
    add_row(mk_item(REQ_KEY, KEY_SW3, 9, 9, 9, 400, 0), 1'b0, '0);
    add_row(mk_item(REQ_KEY, KEY_SW2, 10, 10, 10, 800, 0), 1'b0, '0);
    add_row(mk_item(REQ_READ, KEY_SW3, 0, 0, 0, 50, 0), 1'b0, '0);
    add_row(mk_item(REQ_READ, KEY_SW4, 0, 0, 0, 1023, 9), 1'b0, '0);
    add_row(mk_item(REQ_READ, KEY_NONE, 0, 0, 0, 0, 10), 1'b0, '0);
    add_row(mk_item(REQ_READ, KEY_NONE, 0, 0, 0, 0, 15), 1'b0, '0);

    foreach (dir_rows[i]) drive_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].res);

    counted = 0;
    drawn   = 0;
    while (counted < RAND_ITEMS) begin
      no_idle = (drawn >= 500 && drawn < 800);
      it = rand_item();
      drive_item(it, 1'b0, '0);
      if (!(it.req == REQ_KEY && (it.key == KEY_NONE || it.key > KEY_SW4))) counted++;
      drawn++;
    end
    in_valid_i = 1'b0;
    no_idle    = 1'b0;

    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (pending_results.size() != 0) begin
      mismatches++;
      $display("%0t: outstanding results mismatch, expected 0, actual %0d", $time,
               pending_results.size());
    end

    $display("Sent %0d transactions (%0d from the directed table), checked %0d results.",
             accepted_items, dir_rows.size(), checked_results);
    $display("Model logged %0d records and served %0d reads of stored records; %0d mismatches.",
             logged_records, stored_reads, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
